/* rtl/core/ttq_pkg.sv */
package ttq_pkg;

    localparam int unsigned TimeW  = 32;
    localparam int unsigned CoordW = 12;
    localparam int unsigned SizeW  = 13;
    localparam int unsigned IntvW  = 16;
    localparam int unsigned CfgW   = 16;
    localparam int unsigned InW    = 80;
    localparam int unsigned OutW   = 32;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_SCREEN_WIDTH      = 3'd0,
        CFG_SCREEN_HEIGHT     = 3'd1,
        CFG_REGION_LEFT       = 3'd2,
        CFG_REGION_TOP        = 3'd3,
        CFG_REGION_WIDTH      = 3'd4,
        CFG_REGION_HEIGHT     = 3'd5,
        CFG_DEBOUNCE_INTERVAL = 3'd6,
        CFG_POLL_INTERVAL     = 3'd7
    } cfg_index_t;

    localparam logic [SizeW-1:0]  RstScreenWidth  = 13'd200;
    localparam logic [SizeW-1:0]  RstScreenHeight = 13'd200;
    localparam logic [CoordW-1:0] RstRegionLeft   = 12'd10;
    localparam logic [CoordW-1:0] RstRegionTop    = 12'd15;
    localparam logic [SizeW-1:0]  RstRegionWidth  = 13'd180;
    localparam logic [SizeW-1:0]  RstRegionHeight = 13'd180;
    localparam logic [IntvW-1:0]  RstDebounce     = 16'd700;
    localparam logic [IntvW-1:0]  RstPoll         = 16'd20;

    // one poll request as captured from the input stream
    typedef struct packed {
        logic [7:0]        y_low_byte;
        logic [7:0]        y_high_byte;
        logic [7:0]        x_low_byte;
        logic [7:0]        x_high_byte;
        logic [7:0]        status_byte;
        logic              read_ok;
        logic [TimeW-1:0]  now_ms;
    } poll_t;

    // one result request
    typedef struct packed {
        logic              sensor_up;
        logic              sample_used;
        logic [CoordW-1:0] tap_y;
        logic [CoordW-1:0] tap_x;
        logic              tap_valid;
    } result_t;

    // clamp a 12-bit coordinate to a screen size, size zero acts as one
    function automatic logic [CoordW-1:0] clamp_coord(input logic [CoordW-1:0] v,
                                                      input logic [SizeW-1:0]  size);
        logic [SizeW-1:0] lim;
        logic [SizeW-1:0] top;
        lim = (size == '0) ? SizeW'(1) : size;
        top = lim - SizeW'(1);
        return ({1'b0, v} >= lim) ? top[CoordW-1:0] : v;
    endfunction

endpackage

/* rtl/core/touch_tap_qualifier.sv */
// Touch tap qualifier. Each input request is one poll of a touch controller:
// s_tdata carries the millisecond time stamp, the read-success flag and the raw
// status and coordinate bytes. Every poll gives exactly one result request on
// m_tdata. A poll that is not due (poll_interval not yet elapsed since the last
// due poll) while no touch is held is skipped and reported with sample_used low.
// A failed read drops the sensor-up and touch-held flags; a zero point count
// releases the touch. Only the first poll of a new touch can produce a tap: the
// coordinates are clamped to the screen size, and the tap is reported when
// debounce_interval ms have passed since the previous tap and the point lies in
// the configured rectangle (right and bottom bounds exclusive). A stored time
// of zero means never; time differences wrap modulo 2^32. Throughput is one
// poll per clock while m_tready keeps up: a poll waits in the input register
// while the flags and time stamps are updated, then the result register
// presents it, and only a stalled m_tready holds off s_tready.
// Configuration writes are taken at any time on cfg_valid (cfg_ready is always
// high) and should be made while no poll is in flight.
module touch_tap_qualifier (
    input  logic                   clk,
    input  logic                   rst_n,
    // config write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [ttq_pkg::CfgW-1:0] cfg_data,
    // poll input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // now_ms[31:0], read_ok[32], status_byte[40:33], x_high_byte[48:41],
    // x_low_byte[56:49], y_high_byte[64:57], y_low_byte[72:65], zero pad
    input  logic [ttq_pkg::InW-1:0] s_tdata,
    // result output stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // tap_valid[0], tap_x[12:1], tap_y[24:13], sample_used[25],
    // sensor_up[26], zero pad
    output logic [ttq_pkg::OutW-1:0] m_tdata
);
    import ttq_pkg::*;

    // configuration registers
    logic [SizeW-1:0]  screen_width_reg;
    logic [SizeW-1:0]  screen_height_reg;
    logic [CoordW-1:0] region_left_reg;
    logic [CoordW-1:0] region_top_reg;
    logic [SizeW-1:0]  region_width_reg;
    logic [SizeW-1:0]  region_height_reg;
    logic [IntvW-1:0]  debounce_reg;
    logic [IntvW-1:0]  poll_reg;

    // tracking state
    logic              ready_flag_reg;
    logic              touch_held_reg;
    logic [TimeW-1:0]  last_tap_reg;
    logic [TimeW-1:0]  last_poll_reg;

    // pipeline registers
    logic              in_vld_reg;
    poll_t             in_reg;
    logic              out_vld_reg;
    result_t           out_reg;

    logic              advance;
    logic [TimeW-1:0]  poll_age;
    logic [TimeW-1:0]  tap_age;
    logic              due;
    logic              skip;
    logic              has_point;
    logic [CoordW-1:0] x_clamped;
    logic [CoordW-1:0] y_clamped;
    logic [SizeW:0]    right_edge;
    logic [SizeW:0]    bottom_edge;
    logic              in_region;
    logic              debounce_active;
    logic              tap;
    result_t           result_next;
    logic              ready_flag_next;
    logic              touch_held_next;

    assign cfg_ready = 1'b1;

    // input register moves on whenever the result slot is free or drained
    assign advance  = !out_vld_reg || m_tready;
    assign s_tready = !in_vld_reg || advance;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OutW'(out_reg);

    // poll scheduling and debounce
    assign poll_age = in_reg.now_ms - last_poll_reg;
    assign tap_age  = in_reg.now_ms - last_tap_reg;
    assign due      = (last_poll_reg == '0) || (poll_age >= TimeW'(poll_reg));
    assign skip     = !due && !touch_held_reg;
    assign debounce_active = (last_tap_reg != '0) && (tap_age < TimeW'(debounce_reg));
    assign has_point = (in_reg.status_byte[3:0] != 4'd0);

    // hit test on clamped coordinates
    assign x_clamped = clamp_coord({in_reg.x_high_byte[3:0], in_reg.x_low_byte},
                                   screen_width_reg);
    assign y_clamped = clamp_coord({in_reg.y_high_byte[3:0], in_reg.y_low_byte},
                                   screen_height_reg);
    assign right_edge  = (SizeW+1)'(region_left_reg) + (SizeW+1)'(region_width_reg);
    assign bottom_edge = (SizeW+1)'(region_top_reg) + (SizeW+1)'(region_height_reg);
    assign in_region = (x_clamped >= region_left_reg)
                    && ((SizeW+1)'(x_clamped) < right_edge)
                    && (y_clamped >= region_top_reg)
                    && ((SizeW+1)'(y_clamped) < bottom_edge);

    // a tap needs a fresh touch on a good read
    assign tap = !skip && in_reg.read_ok && has_point && !touch_held_reg
              && !debounce_active && in_region;

    always_comb
    begin
        ready_flag_next = ready_flag_reg;
        touch_held_next = touch_held_reg;
        if (!skip)
        begin
            if (!in_reg.read_ok)
            begin
                ready_flag_next = 1'b0;
                touch_held_next = 1'b0;
            end
            else
            begin
                ready_flag_next = 1'b1;
                touch_held_next = has_point;
            end
        end
        result_next.tap_valid   = tap;
        result_next.tap_x       = tap ? x_clamped : '0;
        result_next.tap_y       = tap ? y_clamped : '0;
        result_next.sample_used = !skip;
        result_next.sensor_up   = ready_flag_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= RstScreenWidth;
            screen_height_reg <= RstScreenHeight;
            region_left_reg   <= RstRegionLeft;
            region_top_reg    <= RstRegionTop;
            region_width_reg  <= RstRegionWidth;
            region_height_reg <= RstRegionHeight;
            debounce_reg      <= RstDebounce;
            poll_reg          <= RstPoll;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SCREEN_WIDTH:      screen_width_reg  <= cfg_data[SizeW-1:0];
                CFG_SCREEN_HEIGHT:     screen_height_reg <= cfg_data[SizeW-1:0];
                CFG_REGION_LEFT:       region_left_reg   <= cfg_data[CoordW-1:0];
                CFG_REGION_TOP:        region_top_reg    <= cfg_data[CoordW-1:0];
                CFG_REGION_WIDTH:      region_width_reg  <= cfg_data[SizeW-1:0];
                CFG_REGION_HEIGHT:     region_height_reg <= cfg_data[SizeW-1:0];
                CFG_DEBOUNCE_INTERVAL: debounce_reg      <= cfg_data[IntvW-1:0];
                CFG_POLL_INTERVAL:     poll_reg          <= cfg_data[IntvW-1:0];
                default:               ;
            endcase
        end
    end

    // state and pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            ready_flag_reg <= 1'b0;
            touch_held_reg <= 1'b0;
            last_tap_reg   <= '0;
            last_poll_reg  <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_vld_reg <= in_vld_reg;
            end
            if (advance && in_vld_reg)
            begin
                ready_flag_reg <= ready_flag_next;
                touch_held_reg <= touch_held_next;
                if (!skip && due)
                begin
                    last_poll_reg <= in_reg.now_ms;
                end
                if (tap)
                begin
                    last_tap_reg <= in_reg.now_ms;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_reg <= poll_t'(s_tdata[$bits(poll_t)-1:0]);
        end
        if (advance && in_vld_reg)
        begin
            out_reg <= result_next;
        end
    end

    // a reported tap always comes from an evaluated poll on a live sensor
    a_tap_used: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_reg.tap_valid |-> out_reg.sample_used && out_reg.sensor_up)
        else $error("tap reported on skipped poll or dead sensor");

    // a tap leaves the touch held and stamps the tap time
    a_tap_holds: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_vld_reg && tap |=> touch_held_reg && last_tap_reg == $past(in_reg.now_ms))
        else $error("tap did not update touch state");

    // skipped polls leave all tracking state alone
    a_skip_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_vld_reg && skip |=> $stable(ready_flag_reg) && $stable(touch_held_reg)
            && $stable(last_poll_reg) && $stable(last_tap_reg))
        else $error("skipped poll changed state");

    // coordinates are zero when no tap is reported
    a_zero_coords: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_reg.tap_valid |-> out_reg.tap_x == '0 && out_reg.tap_y == '0)
        else $error("coordinates present without a tap");

endmodule

/* dv/tb_top.sv */
module tb_top;
    import ttq_pkg::*;

    // watchdog: cycles in a row with no request moving on any channel
    localparam int unsigned IdleLimit = 4000;
    // length of the deliberate output stall that backs the block up
    localparam int unsigned LongHold  = 90;
    // evaluated polls per configuration phase
    localparam int unsigned PhaseUsed = 140;
    // cap on polls sent in one phase when most of them are skipped
    localparam int unsigned PhaseCap  = 700;

    // tracks the tap qualifier's flags and time stamps and holds the expected results
    class tap_tracker;
        logic [SizeW-1:0]  scr_w, scr_h, reg_w, reg_h;
        logic [CoordW-1:0] reg_l, reg_t;
        logic [IntvW-1:0]  debounce, poll_gap;
        logic              sensor_ok, held;
        logic [TimeW-1:0]  last_tap, last_poll;
        result_t           outcomes[$];
        int unsigned       errors, n_polls, n_used, n_taps;

        function new();
            scr_w     = RstScreenWidth;
            scr_h     = RstScreenHeight;
            reg_l     = RstRegionLeft;
            reg_t     = RstRegionTop;
            reg_w     = RstRegionWidth;
            reg_h     = RstRegionHeight;
            debounce  = RstDebounce;
            poll_gap  = RstPoll;
            sensor_ok = 1'b0;
            held      = 1'b0;
            last_tap  = '0;
            last_poll = '0;
            errors    = 0;
            n_polls   = 0;
            n_used    = 0;
            n_taps    = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CfgW-1:0] v);
            case (idx)
                CFG_SCREEN_WIDTH:      scr_w    = v[SizeW-1:0];
                CFG_SCREEN_HEIGHT:     scr_h    = v[SizeW-1:0];
                CFG_REGION_LEFT:       reg_l    = v[CoordW-1:0];
                CFG_REGION_TOP:        reg_t    = v[CoordW-1:0];
                CFG_REGION_WIDTH:      reg_w    = v[SizeW-1:0];
                CFG_REGION_HEIGHT:     reg_h    = v[SizeW-1:0];
                CFG_DEBOUNCE_INTERVAL: debounce = v[IntvW-1:0];
                CFG_POLL_INTERVAL:     poll_gap = v[IntvW-1:0];
                default: ;
            endcase
        endfunction

        // size zero acts as one, sizes above 4096 never clamp
        function logic [CoordW-1:0] clip(logic [CoordW-1:0] v, logic [SizeW-1:0] size);
            int unsigned lim;
            lim = (size == '0) ? 1 : size;
            return (v >= lim) ? CoordW'(lim - 1) : v;
        endfunction

        function void predict_poll(poll_t p);
            result_t          r;
            logic             due;
            logic [CoordW-1:0] x, y;
            logic [TimeW-1:0] since_poll, since_tap;
            int unsigned      right, bottom;
            r = '0;
            n_polls++;
            since_poll = p.now_ms - last_poll;
            due = (last_poll == '0) || (since_poll >= TimeW'(poll_gap));
            if (due || held) begin
                n_used++;
                r.sample_used = 1'b1;
                if (due)
                    last_poll = p.now_ms;
                if (!p.read_ok) begin
                    sensor_ok = 1'b0;
                    held      = 1'b0;
                end
                else begin
                    sensor_ok = 1'b1;
                    if (p.status_byte[3:0] == 4'd0)
                        held = 1'b0;
                    else if (!held) begin
                        // rising edge of a touch: the only place a tap can come from
                        held   = 1'b1;
                        x      = clip({p.x_high_byte[3:0], p.x_low_byte}, scr_w);
                        y      = clip({p.y_high_byte[3:0], p.y_low_byte}, scr_h);
                        right  = reg_l + reg_w;
                        bottom = reg_t + reg_h;
                        since_tap = p.now_ms - last_tap;
                        if ((last_tap == '0 || since_tap >= TimeW'(debounce)) &&
                            x >= reg_l && x < right && y >= reg_t && y < bottom) begin
                            last_tap    = p.now_ms;
                            r.tap_valid = 1'b1;
                            r.tap_x     = x;
                            r.tap_y     = y;
                            n_taps++;
                        end
                    end
                end
            end
            r.sensor_up = sensor_ok;
            outcomes.push_back(r);
        endfunction

        function void report(string field, int unsigned want, int unsigned got);
            $display("%0t: tb_top: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            errors++;
        endfunction

        function void compare_result(result_t got);
            result_t want;
            if (outcomes.size() == 0) begin
                $display("%0t: tb_top: unexpected result, expected none, got %h", $time, got);
                errors++;
                return;
            end
            want = outcomes.pop_front();
            if (got.tap_valid !== want.tap_valid)
                report("tap_valid", want.tap_valid, got.tap_valid);
            if (got.tap_x !== want.tap_x)
                report("tap_x", want.tap_x, got.tap_x);
            if (got.tap_y !== want.tap_y)
                report("tap_y", want.tap_y, got.tap_y);
            if (got.sample_used !== want.sample_used)
                report("sample_used", want.sample_used, got.sample_used);
            if (got.sensor_up !== want.sensor_up)
                report("sensor_up", want.sensor_up, got.sensor_up);
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [2:0]        cfg_index;
    logic [CfgW-1:0]   cfg_data;
    logic              s_tvalid;
    logic              s_tready;
    // now_ms, read_ok, status_byte, x_high_byte, x_low_byte, y_high_byte, y_low_byte
    logic [InW-1:0]    s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    // tap_valid, tap_x, tap_y, sample_used, sensor_up
    logic [OutW-1:0]   m_tdata;

    tap_tracker        tracker;
    logic              burst;       // both sides stop idling while set
    logic              hold_req;    // asks the receiver for one long stall
    logic              touching;    // finger state of the stimulus
    logic [TimeW-1:0]  clock_ms;    // running time stamp of the stimulus
    int unsigned       n_holds, n_settings, idle_cycles;

    touch_tap_qualifier u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    // monitor: register writes, accepted polls and results, plus the watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                tracker.write_reg(cfg_index_t'(cfg_index), cfg_data);
            if (s_tvalid && s_tready)
                tracker.predict_poll(poll_t'(s_tdata[$bits(poll_t)-1:0]));
            if (m_tvalid && m_tready)
                tracker.compare_result(result_t'(m_tdata[$bits(result_t)-1:0]));
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IdleLimit) begin
                $display("%0t: tb_top: no request moved for %0d cycles", $time, IdleLimit);
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    // receiver: random back-pressure per result, one long stall on request
    initial begin
        int unsigned gap;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                n_holds++;
                m_tready <= 1'b0;
                repeat (LongHold) @(negedge clk);
            end
            else begin
                gap = burst ? 0 : $urandom_range(0, 13);
                if (gap != 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            m_tready <= 1'b1;
            do begin
                @(posedge clk);
            end while (!(m_tvalid && m_tready));
        end
    end

    // offer one poll after a random gap and wait until it is taken
    task automatic send_poll(input poll_t p);
        int unsigned gap;
        gap = burst ? 0 : $urandom_range(0, 13);
        @(negedge clk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= InW'(p);
        s_tvalid <= 1'b1;
        do begin
            @(posedge clk);
        end while (!s_tready);
    endtask

    task automatic stop_polls();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // every poll gives one result, so an empty queue means the block is idle
    task automatic drain();
        while (tracker.outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input cfg_index_t idx, input int unsigned v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CfgW'(v);
        do begin
            @(posedge clk);
        end while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input int unsigned sw, input int unsigned sh,
                              input int unsigned l, input int unsigned t,
                              input int unsigned rw, input int unsigned rh,
                              input int unsigned deb, input int unsigned pol);
        drain();
        write_cfg(CFG_SCREEN_WIDTH, sw);
        write_cfg(CFG_SCREEN_HEIGHT, sh);
        write_cfg(CFG_REGION_LEFT, l);
        write_cfg(CFG_REGION_TOP, t);
        write_cfg(CFG_REGION_WIDTH, rw);
        write_cfg(CFG_REGION_HEIGHT, rh);
        write_cfg(CFG_DEBOUNCE_INTERVAL, deb);
        write_cfg(CFG_POLL_INTERVAL, pol);
        n_settings++;
    endtask

    // raw bytes of one poll; unused high nibbles are random
    function automatic poll_t make_poll(input logic [TimeW-1:0] now, input logic ok,
                                        input logic [3:0] count,
                                        input logic [CoordW-1:0] x, input logic [CoordW-1:0] y);
        poll_t p;
        p.now_ms      = now;
        p.read_ok     = ok;
        p.status_byte = {4'($urandom), count};
        p.x_high_byte = {4'($urandom), x[11:8]};
        p.x_low_byte  = x[7:0];
        p.y_high_byte = {4'($urandom), y[11:8]};
        p.y_low_byte  = y[7:0];
        return p;
    endfunction

    // a coordinate that is anywhere, near the tap rectangle, or on the screen
    function automatic logic [CoordW-1:0] pick_coord(input int unsigned start,
                                                     input int unsigned span,
                                                     input int unsigned size);
        int unsigned c;
        case ($urandom_range(0, 2))
            0: c = $urandom_range(0, 4095);
            1: c = start + $urandom_range(0, span);
            default: c = $urandom_range(0, size);
        endcase
        return (c > 4095) ? 12'hFFF : CoordW'(c);
    endfunction

    // touch sessions with random content: press, hold, release, with failed
    // reads, repeated and far-off time stamps and the odd wrap of the clock
    task automatic run_phase(input bit pressure);
        int unsigned used0, sent, advance, slow, tapwin;
        logic [3:0]  count;
        poll_t       p;
        used0  = tracker.n_used;
        sent   = 0;
        slow   = 2 * tracker.poll_gap + 2;
        tapwin = tracker.debounce + tracker.debounce / 2 + 2;
        if (pressure)
            hold_req = 1'b1;
        while (tracker.n_used - used0 < PhaseUsed && sent < PhaseCap) begin
            case ($urandom_range(0, 19))
                0: advance = 0;
                1, 2: advance = $urandom_range(0, tapwin);
                3:
                begin
                    advance  = 0;
                    clock_ms = $urandom_range(0, 1) ? $urandom
                                                    : 32'hFFFF_FFFF - $urandom_range(0, slow);
                end
                default: advance = $urandom_range(0, slow);
            endcase
            clock_ms += advance;
            if ($urandom_range(0, 9) < 3)
                touching = !touching;
            if ($urandom_range(0, 49) == 0)
                burst = !burst;
            count = touching ? 4'($urandom_range(1, 15)) : 4'd0;
            p = make_poll(clock_ms, $urandom_range(0, 19) != 0, count,
                          pick_coord(tracker.reg_l, tracker.reg_w, tracker.scr_w),
                          pick_coord(tracker.reg_t, tracker.reg_h, tracker.scr_h));
            send_poll(p);
            sent++;
        end
        stop_polls();
        burst = 1'b0;
    endtask

    initial begin
        int unsigned sw, sh;
        tracker     = new();
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_SCREEN_WIDTH;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        burst       = 1'b0;
        hold_req    = 1'b0;
        touching    = 1'b0;
        clock_ms    = '0;
        n_holds     = 0;
        n_settings  = 0;
        idle_cycles = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed polls on the reset settings
        // tap at time zero, so the stored tap time still reads as never
        send_poll(make_poll(0, 1, 1, 100, 100));
        send_poll(make_poll(5, 1, 1, 100, 100));          // held, no second tap
        send_poll(make_poll(10, 1, 0, 0, 0));             // release
        send_poll(make_poll(15, 1, 2, 50, 60));           // not due, not held: skipped
        send_poll(make_poll(16, 1, 0, 0, 0));             // not due, not held: skipped
        send_poll(make_poll(17, 1, 1, 70, 70));           // not due, not held: skipped
        send_poll(make_poll(35, 1, 1, 80, 80));           // due, stored tap time still never: tap
        send_poll(make_poll(40, 0, 1, 80, 80));           // failed read drops both flags
        send_poll(make_poll(60, 1, 0, 0, 0));
        send_poll(make_poll(800, 1, 1, 12'hFFF, 12'hFFF)); // clamps, lands outside
        send_poll(make_poll(830, 1, 0, 0, 0));
        send_poll(make_poll(860, 1, 15, 9, 100));         // just left of the rectangle
        send_poll(make_poll(890, 1, 0, 0, 0));
        send_poll(make_poll(920, 1, 1, 10, 15));          // top-left corner, inclusive
        send_poll(make_poll(950, 1, 0, 0, 0));
        send_poll(make_poll(1700, 1, 1, 189, 194));       // last point inside
        send_poll(make_poll(1720, 1, 0, 0, 0));
        send_poll(make_poll(2500, 1, 3, 190, 100));       // right bound is exclusive
        send_poll(make_poll(2520, 1, 0, 0, 0));
        send_poll(make_poll(2540, 1, 4, 100, 195));       // bottom bound is exclusive
        send_poll(make_poll(2560, 1, 0, 0, 0));
        send_poll(make_poll(32'hFFFF_FFF0, 1, 0, 0, 0));
        send_poll(make_poll(32'h0000_0010, 1, 1, 120, 30)); // time wraps, tap
        send_poll(make_poll(32'h0000_0020, 0, 0, 0, 0));
        stop_polls();
        clock_ms = 32'h0000_0040;

        // largest screen and rectangle, no debounce, every poll due
        set_config(4096, 4096, 0, 0, 4096, 4096, 0, 0);
        run_phase(1'b0);
        // one-pixel screen and rectangle, longest intervals
        set_config(1, 1, 0, 0, 1, 1, 65535, 65535);
        run_phase(1'b0);
        // zero width screen clamps x to 0, oversized height never clamps
        set_config(0, 8191, 0, 4095, 1, 4096, 1, 1);
        run_phase(1'b1);
        // empty rectangle
        set_config(320, 240, 4095, 0, 0, 240, 300, 10);
        run_phase(1'b0);
        repeat (5) begin
            sw = $urandom_range(1, 4096);
            sh = $urandom_range(1, 4096);
            set_config(sw, sh, $urandom_range(0, sw - 1), $urandom_range(0, sh - 1),
                       $urandom_range(0, 4096), $urandom_range(0, 4096),
                       $urandom_range(0, 2000), $urandom_range(0, 100));
            run_phase($urandom_range(0, 2) == 0);
        end
        set_config(RstScreenWidth, RstScreenHeight, RstRegionLeft, RstRegionTop,
                   RstRegionWidth, RstRegionHeight, RstDebounce, RstPoll);
        run_phase(1'b1);

        drain();
        repeat (10) @(posedge clk);
        $display("tb_top: %0d polls sent, %0d evaluated, %0d taps qualified",
                 tracker.n_polls, tracker.n_used, tracker.n_taps);
        $display("tb_top: %0d register settings, %0d long output stalls, %0d mismatches",
                 n_settings, n_holds, tracker.errors);
        if (tracker.errors == 0 && tracker.outcomes.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
